// ===== rtl/core/rat_pkg.sv =====
// shared types, constants and helpers of the range assign/add/min/sum table
package rat_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_BLOCK_LEN    = 32;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 10;
  localparam int OPND_W  = 32;
  localparam int VAL_W   = 64;
  localparam int CFG_W   = 11;

  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(1024);
  localparam logic [VAL_W-1:0] MIN_SENTINEL = 64'd2000000000000000000;

  localparam logic [OP_W-1:0] OP_ASSIGN = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd2;
  localparam logic [OP_W-1:0] OP_SUM    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // per-block lazy tags plus summary, one memory word per block
  typedef struct packed {
    logic             assign_pending;
    logic [VAL_W-1:0] assign_value;
    logic [VAL_W-1:0] add_value;
    logic [VAL_W-1:0] total;
    logic [VAL_W-1:0] minimum;
  } tag_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BLK,
    S_TAG,
    S_FULL_SUM,
    S_PART,
    S_PART_TAG,
    S_NEXT,
    S_DONE
  } state_t;

  function automatic logic lt_s(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    lt_s = $signed(a) < $signed(b);
  endfunction

endpackage

// ===== rtl/core/rat_if.sv =====
// channel interfaces for operation and result transactions
interface rat_in_if import rat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [INDEX_W-1:0] first_index;
  logic [INDEX_W-1:0] last_index;
  logic signed [OPND_W-1:0] operand;
  modport source (output valid, operation, first_index, last_index, operand, input ready);
  modport sink   (input valid, operation, first_index, last_index, operand, output ready);
endinterface

interface rat_out_if import rat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [VAL_W-1:0] result_value;
  logic              index_error;
  modport source (output valid, result_value, index_error, input ready);
  modport sink   (input valid, result_value, index_error, output ready);
endinterface

// ===== rtl/core/range_assign_add_min_sum_table.sv =====
// top level: block-decomposed range assign/add/min/sum table
// The table holds MAX_ELEMENTS signed 64-bit elements in one element memory and one tag word per
// block of BLOCK_LEN elements in a tag memory, both with a registered read. After reset a clearing
// pass zeroes both memories, during which no transaction is taken (cfg writes are). Each operation
// then walks the blocks from block 0: a block before the range is passed over, a fully covered block
// takes a tag read, a tag update and for sums a multiply-accumulate, and a partly covered block
// then reads its covered elements for queries, or its whole length for assign and add, since
// assign and add push the tags into all its elements and rebuild its sum and minimum through the
// element memory at one element per cycle. Errors, empty ranges and unused codes skip the walk.
// One operation is in flight at a time; a finished result waits in the output register while the
// next transaction is accepted.
module range_assign_add_min_sum_table import rat_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int BLOCK_LEN    = DEF_BLOCK_LEN
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  rat_in_if.sink           in_ch,
  rat_out_if.source        out_ch
);

  localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SPAN_W = $clog2(MAX_ELEMENTS + BLOCK_LEN + 1);
  localparam int WW     = (SPAN_W > CFG_W) ? SPAN_W : CFG_W;
  localparam int BLEN_W = $clog2(BLOCK_LEN + 1);
  localparam logic [WW-1:0] MAX_WW = WW'(MAX_ELEMENTS);
  localparam logic [WW-1:0] BL_WW  = WW'(BLOCK_LEN);
  localparam logic [WW-1:0] NB_WW  = WW'(NUM_BLOCKS);

  // memories
  logic [VAL_W-1:0] el_mem [MAX_ELEMENTS];
  tag_t             tag_mem [NUM_BLOCKS];
  logic [VAL_W-1:0] el_q_r;
  tag_t             tag_q_r;
  logic             el_re, el_we, tag_re, tag_we;
  logic [IDX_W-1:0] el_ra, el_wa;
  logic [VAL_W-1:0] el_wd;
  logic [BLK_W-1:0] tag_ra, tag_wa;
  tag_t             tag_wd;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [CFG_W-1:0] count_r;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [WW-1:0]    l_r, l_nxt, r_r, r_nxt, bs_r, bs_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [WW-1:0]    iss_r, iss_nxt, iend_r, iend_nxt, rd_a_r, rd_a_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             full_r, full_nxt, first_r, first_nxt, bfirst_r, bfirst_nxt;
  logic             rd_v_r, rd_v_nxt, err_r, err_nxt;
  logic [VAL_W-1:0] x_r, x_nxt, acc_r, acc_nxt, prod_r, prod_nxt, base_r, base_nxt;
  logic [VAL_W-1:0] bsum_r, bsum_nxt, bmin_r, bmin_nxt, res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt, out_err_r, out_err_nxt;
  logic [VAL_W-1:0] out_res_r, out_res_nxt;

  // shared decode
  logic [WW-1:0]    eff_cnt, in_l, in_r, bend, blast, lo_c, hi_c;
  logic [BLEN_W-1:0] blen;
  logic             in_err, in_empty, go_walk, is_mod, is_min, iss_done, out_free;

  assign eff_cnt  = (WW'(count_r) > MAX_WW) ? MAX_WW : WW'(count_r);
  assign in_l     = WW'(in_ch.first_index);
  assign in_r     = WW'(in_ch.last_index);
  assign in_err   = (in_ch.operation <= OP_SUM) ? ((in_l >= eff_cnt) || (in_r >= eff_cnt)) :
                    (in_ch.operation == OP_READ) ? (in_l >= eff_cnt) : 1'b0;
  assign in_empty = (in_ch.operation <= OP_SUM) && (in_l > in_r);
  assign go_walk  = !in_err && !in_empty && (in_ch.operation <= OP_READ);
  assign bend     = bs_r + BL_WW;
  assign blast    = (bend > MAX_WW) ? (MAX_WW - 1'b1) : (bend - 1'b1);
  assign blen     = BLEN_W'(blast - bs_r + 1'b1);
  assign lo_c     = (l_r > bs_r) ? l_r : bs_r;
  assign hi_c     = (r_r < blast) ? r_r : blast;
  assign is_mod   = (op_r == OP_ASSIGN) || (op_r == OP_ADD);
  assign is_min   = (op_r == OP_MIN);
  assign iss_done = iss_r > iend_r;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.index_error  = out_err_r;

  // element memory, registered read
  always_ff @(posedge clk) begin
    if (el_we) begin
      el_mem[el_wa] <= el_wd;
    end
    if (el_re) begin
      el_q_r <= el_mem[el_ra];
    end
  end

  // tag memory, registered read
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (tag_re) begin
      tag_q_r <= tag_mem[tag_ra];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (clr_r == IDX_W'(MAX_ELEMENTS - 1)) state_nxt = S_IDLE;
      S_IDLE:     if (in_ch.valid) state_nxt = go_walk ? S_BLK : S_DONE;
      S_BLK:      if (blast >= l_r) state_nxt = S_TAG;
      S_TAG: begin
        if (!full_r) begin
          state_nxt = S_PART;
        end else if (op_r == OP_SUM || op_r == OP_READ) begin
          state_nxt = S_FULL_SUM;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_FULL_SUM: state_nxt = S_NEXT;
      S_PART:     if (iss_done && !rd_v_r) state_nxt = is_mod ? S_PART_TAG : S_NEXT;
      S_PART_TAG: state_nxt = S_NEXT;
      S_NEXT:     state_nxt = (hi_r == r_r) ? S_DONE : S_BLK;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    logic [VAL_W-1:0] v, nv, m;
    logic             in_rng;
    clr_nxt = clr_r;    op_nxt = op_r;     l_nxt = l_r;       r_nxt = r_r;
    x_nxt = x_r;        bs_nxt = bs_r;     blk_nxt = blk_r;   lo_nxt = lo_r;
    hi_nxt = hi_r;      full_nxt = full_r; acc_nxt = acc_r;   first_nxt = first_r;
    prod_nxt = prod_r;  base_nxt = base_r; iss_nxt = iss_r;   iend_nxt = iend_r;
    rd_v_nxt = 1'b0;    rd_a_nxt = rd_a_r; bsum_nxt = bsum_r; bmin_nxt = bmin_r;
    bfirst_nxt = bfirst_r; res_nxt = res_r; err_nxt = err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt = out_res_r; out_err_nxt = out_err_r;
    el_re = 1'b0; el_ra = iss_r[IDX_W-1:0];
    el_we = 1'b0; el_wa = rd_a_r[IDX_W-1:0]; el_wd = '0;
    tag_re = 1'b0; tag_ra = blk_r;
    tag_we = 1'b0; tag_wa = blk_r; tag_wd = tag_q_r;
    v = '0; nv = '0; m = '0; in_rng = 1'b0;
    case (state_r)
      S_CLEAR: begin
        el_we   = 1'b1;
        el_wa   = clr_r;
        tag_we  = (WW'(clr_r) < NB_WW);
        tag_wa  = clr_r[BLK_W-1:0];
        tag_wd  = '0;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          l_nxt     = in_l;
          r_nxt     = (in_ch.operation == OP_READ) ? in_l : in_r;
          x_nxt     = VAL_W'($signed(in_ch.operand));
          bs_nxt    = '0;
          blk_nxt   = '0;
          acc_nxt   = '0;
          first_nxt = 1'b1;
          err_nxt   = in_err;
          res_nxt   = (in_empty && !in_err && in_ch.operation == OP_MIN) ? MIN_SENTINEL : '0;
        end
      end
      S_BLK: begin
        if (blast < l_r) begin
          // block lies wholly before the range
          bs_nxt  = bend;
          blk_nxt = blk_r + 1'b1;
        end else begin
          lo_nxt   = lo_c;
          hi_nxt   = hi_c;
          full_nxt = (lo_c == bs_r) && (hi_c == blast);
          tag_re   = 1'b1;
        end
      end
      S_TAG: begin
        if (full_r) begin
          case (op_r)
            OP_ASSIGN: begin
              tag_we = 1'b1;
              tag_wd.assign_pending = 1'b1;
              tag_wd.assign_value   = x_r;
              tag_wd.add_value      = '0;
            end
            OP_ADD: begin
              tag_we = 1'b1;
              tag_wd.add_value = tag_q_r.add_value + x_r;
            end
            OP_MIN: begin
              m = (tag_q_r.assign_pending ? tag_q_r.assign_value : tag_q_r.minimum)
                  + tag_q_r.add_value;
              if (first_r || lt_s(m, acc_r)) acc_nxt = m;
              first_nxt = 1'b0;
            end
            default: begin
              prod_nxt = VAL_W'((tag_q_r.assign_pending ?
                                 tag_q_r.assign_value + tag_q_r.add_value :
                                 tag_q_r.add_value) * VAL_W'(blen));
              base_nxt = tag_q_r.assign_pending ? '0 : tag_q_r.total;
            end
          endcase
        end else begin
          iss_nxt    = is_mod ? bs_r : lo_r;
          iend_nxt   = is_mod ? blast : hi_r;
          bsum_nxt   = '0;
          bfirst_nxt = 1'b1;
        end
      end
      S_FULL_SUM: acc_nxt = acc_r + base_r + prod_r;
      S_PART: begin
        if (!iss_done) begin
          el_re    = 1'b1;
          iss_nxt  = iss_r + 1'b1;
          rd_v_nxt = 1'b1;
          rd_a_nxt = iss_r;
        end
        if (rd_v_r) begin
          v = (tag_q_r.assign_pending ? tag_q_r.assign_value : el_q_r) + tag_q_r.add_value;
          if (is_mod) begin
            // push tags, apply the operand inside the range, rebuild summary
            in_rng = (rd_a_r >= lo_r) && (rd_a_r <= hi_r);
            nv = in_rng ? ((op_r == OP_ASSIGN) ? x_r : v + x_r) : v;
            el_we    = 1'b1;
            el_wd    = nv;
            bsum_nxt = bsum_r + nv;
            if (bfirst_r || lt_s(nv, bmin_r)) bmin_nxt = nv;
            bfirst_nxt = 1'b0;
          end else if (is_min) begin
            if (first_r || lt_s(v, acc_r)) acc_nxt = v;
            first_nxt = 1'b0;
          end else begin
            acc_nxt = acc_r + v;
          end
        end
      end
      S_PART_TAG: begin
        tag_we = 1'b1;
        tag_wd = '{assign_pending: 1'b0, assign_value: '0, add_value: '0,
                   total: bsum_r, minimum: bmin_r};
      end
      S_NEXT: begin
        if (hi_r == r_r) begin
          res_nxt = is_mod ? '0 : acc_r;
        end else begin
          bs_nxt  = bend;
          blk_nxt = blk_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_err_nxt   = err_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= rd_v_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;       l_r <= l_nxt;         r_r <= r_nxt;       x_r <= x_nxt;
    bs_r <= bs_nxt;       blk_r <= blk_nxt;     lo_r <= lo_nxt;     hi_r <= hi_nxt;
    full_r <= full_nxt;   acc_r <= acc_nxt;     first_r <= first_nxt;
    prod_r <= prod_nxt;   base_r <= base_nxt;   iss_r <= iss_nxt;   iend_r <= iend_nxt;
    rd_a_r <= rd_a_nxt;   bsum_r <= bsum_nxt;   bmin_r <= bmin_nxt; bfirst_r <= bfirst_nxt;
    res_r <= res_nxt;     err_r <= err_nxt;
    out_res_r <= out_res_nxt; out_err_r <= out_err_nxt;
  end

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("transaction taken during clearing pass");

  a_el_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    el_we |-> (state_r == S_CLEAR || state_r == S_PART))
    else $error("element write outside clear or partial block walk");

  a_tag_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |-> (state_r == S_CLEAR || state_r == S_TAG || state_r == S_PART_TAG))
    else $error("tag write in unexpected state");

  a_error_short: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_err) |=> (state_r == S_DONE && err_r))
    else $error("index error did not finish at once");
`endif

endmodule

// ===== dv/tb_range_assign_add_min_sum_table.sv =====
// testbench for the range assign/add/min/sum table: random and directed operations checked against a block-level model
module tb_range_assign_add_min_sum_table;
  import rat_pkg::*;

  localparam int NELEM = DEF_MAX_ELEMENTS;
  localparam int BLEN  = DEF_BLOCK_LEN;
  localparam int NBLK  = (NELEM + BLEN - 1) / BLEN;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] last_index;
    logic [OPND_W-1:0]  operand;
  } op_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic             index_error;
  } answer_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rat_in_if  in_ch ();
  rat_out_if out_ch ();

  range_assign_add_min_sum_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // shadow of the table: elements plus per-block lazy tags
  logic [VAL_W-1:0] shadow_elem [NELEM];
  logic [VAL_W-1:0] shadow_set  [NBLK];
  logic             shadow_setp [NBLK];
  logic [VAL_W-1:0] shadow_add  [NBLK];
  logic [VAL_W-1:0] shadow_tot  [NBLK];
  logic [VAL_W-1:0] shadow_min  [NBLK];
  logic [CFG_W-1:0] shadow_count;

  op_item_t pending_ops [$];
  answer_t  expected_answers [$];

  int  n_sent, n_checked, n_errors_seen;
  bit  failed;
  int  idle_cycles;
  bit  drain_mode;

  function automatic logic less_s(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic int blk_end(int b);
    return (b * BLEN + BLEN > NELEM) ? NELEM : b * BLEN + BLEN;
  endfunction

  function automatic logic [VAL_W-1:0] elem_value(int i);
    int b;
    b = i / BLEN;
    return (shadow_setp[b] ? shadow_set[b] : shadow_elem[i]) + shadow_add[b];
  endfunction

  // push pending tags into the elements of block b
  function automatic void flatten_block(int b);
    for (int k = b * BLEN; k < blk_end(b); k++)
      shadow_elem[k] = (shadow_setp[b] ? shadow_set[b] : shadow_elem[k]) + shadow_add[b];
    shadow_setp[b] = 1'b0;
    shadow_set[b]  = '0;
    shadow_add[b]  = '0;
  endfunction

  function automatic void resummarise(int b);
    logic [VAL_W-1:0] s, m;
    s = '0;
    m = shadow_elem[b * BLEN];
    for (int k = b * BLEN; k < blk_end(b); k++) begin
      s += shadow_elem[k];
      if (less_s(shadow_elem[k], m)) m = shadow_elem[k];
    end
    shadow_tot[b] = s;
    shadow_min[b] = m;
  endfunction

  // range walk over blocks, updating the shadow for assign and add
  function automatic logic [VAL_W-1:0] walk_range(logic [OP_W-1:0] op, int l, int r,
                                                  logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] acc, m, v, blen;
    bit first;
    int i, b, bs, be, stop;
    acc = (op == OP_MIN) ? MIN_SENTINEL : '0;
    first = 1'b1;
    i = l;
    while (i <= r) begin
      b = i / BLEN;
      bs = b * BLEN;
      be = blk_end(b);
      stop = (r + 1 < be) ? r + 1 : be;
      blen = VAL_W'(be - bs);
      if (i == bs && stop == be) begin
        case (op)
          OP_ASSIGN: begin
            shadow_setp[b] = 1'b1;
            shadow_set[b]  = x;
            shadow_add[b]  = '0;
          end
          OP_ADD: shadow_add[b] += x;
          OP_MIN: begin
            m = (shadow_setp[b] ? shadow_set[b] : shadow_min[b]) + shadow_add[b];
            if (first || less_s(m, acc)) acc = m;
            first = 1'b0;
          end
          default: begin
            if (shadow_setp[b]) acc += (shadow_set[b] + shadow_add[b]) * blen;
            else acc += shadow_tot[b] + shadow_add[b] * blen;
          end
        endcase
      end else if (op == OP_ASSIGN || op == OP_ADD) begin
        flatten_block(b);
        for (int k = i; k < stop; k++)
          shadow_elem[k] = (op == OP_ASSIGN) ? x : shadow_elem[k] + x;
        resummarise(b);
      end else begin
        for (int k = i; k < stop; k++) begin
          v = elem_value(k);
          if (op == OP_MIN) begin
            if (first || less_s(v, acc)) acc = v;
            first = 1'b0;
          end else begin
            acc += v;
          end
        end
      end
      i = stop;
    end
    return acc;
  endfunction

  function automatic answer_t predict_answer(op_item_t it);
    answer_t a;
    int cnt, l, r;
    logic [VAL_W-1:0] x;
    cnt = (shadow_count > NELEM) ? NELEM : shadow_count;
    l = it.first_index;
    r = it.last_index;
    x = VAL_W'($signed(it.operand));
    a = '0;
    if (it.operation <= OP_SUM) begin
      if (l >= cnt || r >= cnt) a.index_error = 1'b1;
      else if (l > r) a.result_value = (it.operation == OP_MIN) ? MIN_SENTINEL : '0;
      else begin
        a.result_value = walk_range(it.operation, l, r, x);
        if (it.operation == OP_ASSIGN || it.operation == OP_ADD) a.result_value = '0;
      end
    end else if (it.operation == OP_READ) begin
      if (l >= cnt) a.index_error = 1'b1;
      else a.result_value = elem_value(l);
    end
    return a;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // append one operation to the pending queue
  function automatic void queue_op(op_item_t it);
    pending_ops.insert(pending_ops.size(), it);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: one transaction at a time from the pending queue
  int drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        answer_t ans;
        ans = predict_answer({in_ch.operation, in_ch.first_index,
                              in_ch.last_index, in_ch.operand});
        expected_answers.insert(expected_answers.size(), ans);
        n_sent++;
      end
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !drain_mode) begin
        op_item_t it;
        it = pending_ops.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= it.operation;
        in_ch.first_index <= it.first_index;
        in_ch.last_index  <= it.last_index;
        in_ch.operand     <= it.operand;
        drv_gap <= gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compare every result transaction with the oldest expectation
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result value=%h err=%b", $time,
                   out_ch.result_value, out_ch.index_error);
          failed = 1'b1;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (out_ch.index_error) n_errors_seen++;
          if (e.result_value !== out_ch.result_value)begin
            $display("%0t: result_value expected %h actual %h", $time,
                     e.result_value, out_ch.result_value);
            failed = 1'b1;
          end
          if (e.index_error !== out_ch.index_error) begin
            $display("%0t: index_error expected %b actual %b", $time,
                     e.index_error, out_ch.index_error);
            failed = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= gap_len();
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[range_assign_add_min_sum_table] ERROR");
      $finish;
    end
  end

  function automatic op_item_t mk(logic [OP_W-1:0] op, int l, int r, logic [OPND_W-1:0] x);
    op_item_t it;
    it.operation = op;
    it.first_index = INDEX_W'(l);
    it.last_index = INDEX_W'(r);
    it.operand = x;
    return it;
  endfunction

  // random operation biased towards valid ranges inside the active count
  function automatic op_item_t rand_op(int cnt);
    op_item_t it;
    int l, r, p, lim;
    lim = (cnt < 1) ? 1 : cnt;
    p = $urandom_range(99);
    if (p < 25) it.operation = OP_ASSIGN;
    else if (p < 50) it.operation = OP_ADD;
    else if (p < 68) it.operation = OP_MIN;
    else if (p < 84) it.operation = OP_SUM;
    else if (p < 97) it.operation = OP_READ;
    else it.operation = OP_W'($urandom_range(7, 5));
    l = $urandom_range(lim - 1);
    r = $urandom_range(lim - 1);
    if (l > r && $urandom_range(9) < 8) begin
      int t; t = l; l = r; r = t;
    end
    if ($urandom_range(19) == 0) l = $urandom_range(NELEM - 1);
    if ($urandom_range(19) == 0) r = $urandom_range(NELEM - 1);
    if ($urandom_range(9) == 0) r = l + $urandom_range(3);
    if (r > NELEM - 1) r = NELEM - 1;
    it.first_index = INDEX_W'(l);
    it.last_index = INDEX_W'(r);
    p = $urandom_range(9);
    if (p == 0) it.operand = 32'h8000_0000;
    else if (p == 1) it.operand = 32'h7fff_ffff;
    else if (p < 5) it.operand = OPND_W'($urandom_range(20)) - 32'd10;
    else it.operand = $urandom;
    return it;
  endfunction

  task automatic run_ops();
    while (pending_ops.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_count(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_count = CFG_W'(v);
  endtask

  initial begin
    int counts [6];
    for (int k = 0; k < NELEM; k++) shadow_elem[k] = '0;
    for (int b = 0; b < NBLK; b++) begin
      shadow_set[b] = '0; shadow_setp[b] = 1'b0; shadow_add[b] = '0;
      shadow_tot[b] = '0; shadow_min[b] = '0;
    end
    shadow_count = COUNT_RESET;
    failed = 1'b0;
    drain_mode = 1'b0;
    n_sent = 0; n_checked = 0; n_errors_seen = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.first_index = '0;
    in_ch.last_index = '0;
    in_ch.operand = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every code, empty ranges
    queue_op(mk(OP_MIN, 0, 1023, '0));
    queue_op(mk(OP_ASSIGN, 0, 1023, 32'h7fff_ffff));
    queue_op(mk(OP_SUM, 0, 1023, '0));
    queue_op(mk(OP_ADD, 5, 1000, 32'h8000_0000));
    queue_op(mk(OP_MIN, 0, 1023, '0));
    queue_op(mk(OP_SUM, 3, 37, '0));
    queue_op(mk(OP_READ, 1023, 0, '0));
    queue_op(mk(OP_READ, 6, 0, '0));
    queue_op(mk(OP_ASSIGN, 40, 20, 32'h1234));
    queue_op(mk(OP_ADD, 40, 20, 32'h1234));
    queue_op(mk(OP_MIN, 40, 20, '0));
    queue_op(mk(OP_SUM, 40, 20, '0));
    queue_op(mk(OP_ASSIGN, 64, 95, 32'hffff_ffff));
    queue_op(mk(OP_MIN, 60, 100, '0));
    queue_op(mk(OP_READ, 70, 0, '0));
    queue_op(mk(3'd5, 1, 2, 32'h55));
    queue_op(mk(3'd6, 1023, 1023, 32'haa));
    queue_op(mk(3'd7, 0, 0, 32'hffff_ffff));
    queue_op(mk(OP_SUM, 1023, 1023, '0));
    queue_op(mk(OP_ADD, 512, 512, 32'h8000_0000));
    queue_op(mk(OP_READ, 512, 1023, '0));
    run_ops();

    // phases over several element counts, including zero and above the maximum
    counts = '{1, 0, 2047, 37, 1024, 700};
    foreach (counts[c]) begin
      int cnt;
      set_count(counts[c]);
      cnt = (counts[c] > NELEM) ? NELEM : counts[c];
      queue_op(mk(OP_READ, 1023, 0, '0));
      for (int n = 0; n < ((c == 1) ? 20 : 240); n++) queue_op(rand_op(cnt));
      run_ops();
    end

    $display("covered %0d operations over six element counts, %0d results checked,",
             n_sent, n_checked);
    $display("%0d of them index errors", n_errors_seen);
    if (!failed && expected_answers.size() == 0) begin
      $display("[range_assign_add_min_sum_table] OK");
    end else begin
      $display("[range_assign_add_min_sum_table] ERROR");
    end
    $finish;
  end

endmodule
